// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the SHA-1 hasher.
// Define ASSERT_OFF to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property at every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds at a rising edge of clk outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/sha1sh_pkg.sv =====
// Package for the SHA-1 stream hasher: round constants, initial chaining
// values and shared types. No dependencies.
package sha1sh_pkg;

    typedef logic [31:0] word_t;
    typedef word_t       chain_t [5];

    localparam word_t K_ROUND0 = 32'h5a82_7999;
    localparam word_t K_ROUND1 = 32'h6ed9_eba1;
    localparam word_t K_ROUND2 = 32'h8f1b_bcdc;
    localparam word_t K_ROUND3 = 32'hca62_c1d6;

    localparam word_t H_INIT0 = 32'h6745_2301;
    localparam word_t H_INIT1 = 32'hefcd_ab89;
    localparam word_t H_INIT2 = 32'h98ba_dcfe;
    localparam word_t H_INIT3 = 32'h1032_5476;
    localparam word_t H_INIT4 = 32'hc3d2_e1f0;

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam int         NUM_ROUNDS   = 80;
    localparam logic [2:0] LAST_WORD_IX = 3'd4;
    localparam logic [5:0] LEN_START    = 6'd56;
    localparam logic [5:0] BLOCK_LAST   = 6'd63;

    function automatic word_t rotl(input word_t x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

// ===== src/sha1_stream_hasher_unit.sv =====
// SHA-1 stream hasher top level: byte gathering, padding, iterative
// 80-round compression and digest output.
// Depends on sha1sh_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries msg_byte, byte_valid and
//   end_msg. A byte is written into the 16-word block window; the 64th byte
//   of a block starts a compression. end_msg closes the message after the
//   byte of the same transaction, if any.
//   Output channel (out_valid/out_ready) carries the five digest words,
//   word_index 0..4, last_word high on the fifth.
//   A block compression runs 80 rounds through one shared round adder, then
//   one chaining add. Padding writes one byte per cycle from the fill
//   position to the end of the block, plus a whole second block when fewer
//   than nine slots are free; padding ends in one or two compressions, then
//   five output transactions. in_ready is low while a block is in work.
//   A stalled receiver holds the current digest word; nothing is lost.
//   Reset loads the initial chaining values, clears the byte count and
//   leaves the block idle and ready.
`include "assert_macros.svh"

module sha1_stream_hasher_unit
    import sha1sh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  msg_byte,
    input  logic        byte_valid,
    input  logic        end_msg,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FINAL = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [6:0] ROUND_LAST = 7'(NUM_ROUNDS - 1);

    logic [2:0]  state_reg, state_next;
    logic [6:0]  round_reg, round_next;
    logic [60:0] count_reg, count_next;
    logic [5:0]  ptr_reg, ptr_next;
    logic        first_reg, first_next;
    logic        len_blk_reg, len_blk_next;
    logic        in_pad_reg, in_pad_next;
    logic        pend_end_reg, pend_end_next;
    logic [2:0]  idx_reg, idx_next;
    chain_t      chain_reg, chain_next;
    word_t       a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t       a_next, b_next, c_next, d_next, e_next;
    word_t       win_reg [16];
    word_t       win_next [16];

    logic        in_fire, out_fire;
    logic        wr_en;
    logic [5:0]  wr_ptr;
    logic [7:0]  wr_data;
    logic [5:0]  fill_pos;
    logic [63:0] len_bits;
    word_t       w_cur, f_cur, k_cur, t_sum;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign in_fire     = in_valid && in_ready;
    assign out_fire    = out_valid && out_ready;
    assign digest_word = chain_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == LAST_WORD_IX);
    assign len_bits    = {count_reg, 3'b000};

    // round function: one shared five-term adder
    always_comb
    begin
        if (round_reg < 7'd16)
        begin
            w_cur = win_reg[0];
        end
        else
        begin
            w_cur = rotl(win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0], 1);
        end
        if (round_reg < 7'd20)
        begin
            f_cur = (b_reg & c_reg) | (~b_reg & d_reg);
            k_cur = K_ROUND0;
        end
        else if (round_reg < 7'd40)
        begin
            f_cur = b_reg ^ c_reg ^ d_reg;
            k_cur = K_ROUND1;
        end
        else if (round_reg < 7'd60)
        begin
            f_cur = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_cur = K_ROUND2;
        end
        else
        begin
            f_cur = b_reg ^ c_reg ^ d_reg;
            k_cur = K_ROUND3;
        end
        t_sum = rotl(a_reg, 5) + f_cur + e_reg + k_cur + w_cur;
    end

    always_comb
    begin
        state_next    = state_reg;
        round_next    = round_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        first_next    = first_reg;
        len_blk_next  = len_blk_reg;
        in_pad_next   = in_pad_reg;
        pend_end_next = pend_end_reg;
        idx_next      = idx_reg;
        chain_next    = chain_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        d_next        = d_reg;
        e_next        = e_reg;
        wr_en         = 1'b0;
        wr_ptr        = count_reg[5:0];
        wr_data       = msg_byte;
        fill_pos      = count_reg[5:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (byte_valid)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 61'd1;
                    end
                    fill_pos      = count_next[5:0];
                    pend_end_next = end_msg;
                    in_pad_next   = 1'b0;
                    if (byte_valid && (count_reg[5:0] == BLOCK_LAST))
                    begin
                        state_next = ST_ROUND;
                        round_next = '0;
                        a_next     = chain_reg[0];
                        b_next     = chain_reg[1];
                        c_next     = chain_reg[2];
                        d_next     = chain_reg[3];
                        e_next     = chain_reg[4];
                    end
                    else if (end_msg)
                    begin
                        state_next   = ST_PAD;
                        ptr_next     = fill_pos;
                        first_next   = 1'b1;
                        len_blk_next = (fill_pos < LEN_START);
                    end
                end
            end
            ST_PAD:
            begin
                wr_en  = 1'b1;
                wr_ptr = ptr_reg;
                if (first_reg)
                begin
                    wr_data = PAD_MARK;
                end
                else if (len_blk_reg && (ptr_reg >= LEN_START))
                begin
                    wr_data = len_bits[{~ptr_reg[2:0], 3'b000} +: 8];
                end
                else
                begin
                    wr_data = 8'h00;
                end
                first_next = 1'b0;
                ptr_next   = ptr_reg + 6'd1;
                if (ptr_reg == BLOCK_LAST)
                begin
                    state_next  = ST_ROUND;
                    round_next  = '0;
                    in_pad_next = 1'b1;
                    a_next      = chain_reg[0];
                    b_next      = chain_reg[1];
                    c_next      = chain_reg[2];
                    d_next      = chain_reg[3];
                    e_next      = chain_reg[4];
                end
            end
            ST_ROUND:
            begin
                e_next     = d_reg;
                d_next     = c_reg;
                c_next     = rotl(b_reg, 30);
                b_next     = a_reg;
                a_next     = t_sum;
                round_next = round_reg + 7'd1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                if (in_pad_reg)
                begin
                    if (len_blk_reg)
                    begin
                        state_next = ST_OUT;
                        idx_next   = '0;
                    end
                    else
                    begin
                        // length goes into one more all-padding block
                        state_next   = ST_PAD;
                        ptr_next     = '0;
                        len_blk_next = 1'b1;
                    end
                end
                else if (pend_end_reg)
                begin
                    state_next   = ST_PAD;
                    ptr_next     = '0;
                    first_next   = 1'b1;
                    len_blk_next = 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    if (idx_reg == LAST_WORD_IX)
                    begin
                        // digest delivered: start a fresh message
                        state_next    = ST_IDLE;
                        count_next    = '0;
                        pend_end_next = 1'b0;
                        chain_next[0] = H_INIT0;
                        chain_next[1] = H_INIT1;
                        chain_next[2] = H_INIT2;
                        chain_next[3] = H_INIT3;
                        chain_next[4] = H_INIT4;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // schedule window: byte writes while filling, rolling shift in rounds
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = w_cur;
        end
        else if (wr_en)
        begin
            win_next[wr_ptr[5:2]][{~wr_ptr[1:0], 3'b000} +: 8] = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            first_reg     <= 1'b0;
            len_blk_reg   <= 1'b0;
            in_pad_reg    <= 1'b0;
            pend_end_reg  <= 1'b0;
            idx_reg       <= '0;
            chain_reg[0]  <= H_INIT0;
            chain_reg[1]  <= H_INIT1;
            chain_reg[2]  <= H_INIT2;
            chain_reg[3]  <= H_INIT3;
            chain_reg[4]  <= H_INIT4;
        end
        else
        begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            count_reg    <= count_next;
            ptr_reg      <= ptr_next;
            first_reg    <= first_next;
            len_blk_reg  <= len_blk_next;
            in_pad_reg   <= in_pad_next;
            pend_end_reg <= pend_end_next;
            idx_reg      <= idx_next;
            chain_reg    <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
        for (int i = 0; i < 16; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

    `ASSERT_NEVER(a_round_range, (state_reg == ST_ROUND) && (round_reg > ROUND_LAST), "round counter past last round")
    `ASSERT_NEVER(a_index_range, out_valid && (word_index > LAST_WORD_IX), "digest word index out of range")
    `ASSERT_CLK(a_restart, (out_fire && last_word) |=> (in_ready && (count_reg == '0)), "message state not cleared after digest")
    `ASSERT_CLK(a_pad_start, ((state_reg == ST_PAD) && first_reg) |=> ((state_reg == ST_PAD) || (state_reg == ST_ROUND)), "pad mark write left padding early")
    `ASSERT_CLK(a_final_once, (state_reg == ST_FINAL) |=> (state_reg != ST_FINAL), "chaining add repeated")

endmodule

// ===== tb/sha1_digest_checker.sv =====
// Digest checker for the SHA-1 stream hasher: watches both channels, keeps a
// bit-true SHA-1 predictor and compares every digest transaction.
// Depends on sha1sh_pkg.
module sha1_digest_checker
    import sha1sh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  msg_byte,
    input  logic        byte_valid,
    input  logic        end_msg,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          fail_count,
    output int          words_pending,
    output int          words_checked,
    output int          messages_closed,
    output int          blocks_hashed
);

    typedef struct packed {
        word_t      word;
        logic [2:0] idx;
        logic       last;
    } digest_entry_t;

    word_t         hash_state [5];
    logic [7:0]    block_bytes [64];
    logic [60:0]   msg_len;
    digest_entry_t digest_q [$];

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
        fail_count++;
    endtask

    function automatic void load_initial_chain();
        hash_state[0] = H_INIT0;
        hash_state[1] = H_INIT1;
        hash_state[2] = H_INIT2;
        hash_state[3] = H_INIT3;
        hash_state[4] = H_INIT4;
        msg_len = '0;
    endfunction

    function automatic void compress_block_bytes();
        word_t sched [16];
        word_t a, b, c, d, e, f, k, sum, mix;
        for (int i = 0; i < 16; i++)
            sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int r = 0; r < NUM_ROUNDS; r++)
        begin
            // extend the schedule in place over a 16-word window
            if (r >= 16)
            begin
                mix = sched[(r+13)%16] ^ sched[(r+8)%16] ^ sched[(r+2)%16] ^ sched[r%16];
                sched[r%16] = {mix[30:0], mix[31]};
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_ROUND0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K_ROUND1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
            sum = {a[26:0], a[31:27]} + f + e + k + sched[r%16];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
        blocks_hashed++;
    endfunction

    function automatic void absorb_transaction(input logic [7:0] data, input logic take,
                                               input logic close);
        int          pos;
        logic [63:0] bit_len;
        if (take)
        begin
            pos = int'(msg_len[5:0]);
            block_bytes[pos] = data;
            msg_len++;
            if (pos == BLOCK_LAST)
                compress_block_bytes();
        end
        if (!close)
            return;
        pos = int'(msg_len[5:0]);
        block_bytes[pos] = PAD_MARK;
        pos++;
        // no room for the length: finish this block and pad a fresh one
        if (pos > LEN_START)
        begin
            while (pos < 64)
            begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            compress_block_bytes();
            pos = 0;
        end
        while (pos < LEN_START)
        begin
            block_bytes[pos] = 8'h00;
            pos++;
        end
        bit_len = {msg_len, 3'b000};
        for (int i = 0; i < 8; i++)
            block_bytes[LEN_START + i] = bit_len[63 - 8*i -: 8];
        compress_block_bytes();
        for (int i = 0; i < 5; i++)
            digest_q.push_back('{word: hash_state[i], idx: 3'(i),
                                 last: (3'(i) == LAST_WORD_IX)});
        load_initial_chain();
        messages_closed++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digest_entry_t want;
        if (!rst_n)
        begin
            load_initial_chain();
            digest_q.delete();
            fail_count      <= 0;
            words_pending   <= 0;
            words_checked   <= 0;
            messages_closed <= 0;
            blocks_hashed   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                    report_mismatch("digest transaction with nothing expected", '0, digest_word);
                else
                begin
                    want = digest_q.pop_front();
                    if (digest_word !== want.word)
                        report_mismatch("digest_word", want.word, digest_word);
                    if (word_index !== want.idx)
                        report_mismatch("word_index", 32'(want.idx), 32'(word_index));
                    if (last_word !== want.last)
                        report_mismatch("last_word", 32'(want.last), 32'(last_word));
                    words_checked++;
                end
            end
            if (in_valid && in_ready)
                absorb_transaction(msg_byte, byte_valid, end_msg);
            words_pending <= digest_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for sha1_stream_hasher_unit: drives message bytes and
// end-of-message transactions, throttles the digest side, gives the verdict.
// Depends on sha1_stream_hasher_unit and sha1_digest_checker.
module tb_top;

    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 38;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  msg_byte;
    logic        byte_valid;
    logic        end_msg;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int fail_count;
    int words_pending;
    int words_checked;
    int messages_closed;
    int blocks_hashed;

    bit no_stall     = 1'b0;
    int byte_items   = 0;
    int end_items    = 0;
    int idle_items   = 0;
    int quiet_cycles = 0;
    int pad_edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    sha1_stream_hasher_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .msg_byte    (msg_byte),
        .byte_valid  (byte_valid),
        .end_msg     (end_msg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    sha1_digest_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .msg_byte        (msg_byte),
        .byte_valid      (byte_valid),
        .end_msg         (end_msg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .digest_word     (digest_word),
        .word_index      (word_index),
        .last_word       (last_word),
        .fail_count      (fail_count),
        .words_pending   (words_pending),
        .words_checked   (words_checked),
        .messages_closed (messages_closed),
        .blocks_hashed   (blocks_hashed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
        out_ready = 1'b0;

    always @(negedge clk)
        out_ready <= no_stall || ($urandom_range(0, 99) >= IDLE_PCT);

    // end the run when no transaction moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles == STALL_LIMIT)
            begin
                $display("sha1_stream_hasher_unit: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [7:0] data, input logic take, input logic close);
        int gap;
        gap = 0;
        if (!no_stall)
            while ($urandom_range(0, 99) < IDLE_PCT)
                gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        msg_byte   <= data;
        byte_valid <= take;
        end_msg    <= close;
        // hold until the transaction is taken
        do @(posedge clk); while (!in_ready);
        if (take)
            byte_items++;
        if (close)
            end_items++;
        if (!take && !close)
            idle_items++;
    endtask

    task automatic send_message(input int len, input bit merge_end);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, merge_end && (i == len - 1));
        end
        if (!merge_end || len == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial
    begin
        int len;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        msg_byte   = 8'h00;
        byte_valid = 1'b0;
        end_msg    = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // empty messages back to back, stray byte ignored
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        // "abc" with the last byte and the close in one transaction
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // byte extremes with an idle transaction in between
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b1);
        send_item(8'h7F, 1'b1, 1'b1);

        while (byte_items + end_items < 350 || messages_closed < 10)
        begin
            no_stall = (byte_items >= 150 && byte_items < 260);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = $urandom_range(0, 12);
                5, 6, 7:       len = pad_edges[$urandom_range(0, 9)];
                default:       len = $urandom_range(0, 130);
            endcase
            send_message(len, 1'($urandom_range(0, 1)));
        end
        no_stall = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        while (words_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d messages: %0d byte, %0d close and %0d idle transactions",
                 messages_closed, byte_items, end_items, idle_items);
        $display("%0d blocks compressed, %0d digest words compared",
                 blocks_hashed, words_checked);
        if (fail_count == 0)
            $display("sha1_stream_hasher_unit: match");
        else
            $display("sha1_stream_hasher_unit: mismatch");
        $finish;
    end

endmodule
